@@ sv/tclc_pkg.sv @@
// tclc_pkg: shared types, constants and helpers for the tile color lut classifier
// depends on nothing; imported by tile_color_lut_classifier_top
package tclc_pkg;

    localparam int QUANT_STEP      = 16;
    localparam int LEVELS          = 16;
    localparam int MAX_TILE_PIXELS = 4096;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = 12;
    localparam int COUNT_W     = 24;
    localparam int TOTAL_W     = COUNT_W + 2;
    localparam int FRAC_W      = 17;
    localparam int SUM_W       = 29;
    localparam int ALPHA_W     = 16;
    localparam int CH_W        = 8;
    localparam int NCLASS      = 4;
    localparam int ENTRY_W     = NCLASS * FRAC_W;
    localparam int STEP_W      = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;

    localparam longint SUM_FULL  = longint'(MAX_TILE_PIXELS) * 65536;
    localparam longint SUM_CAP   = 536870911;
    localparam logic [SUM_W-1:0] SUM_LIMIT =
        SUM_W'((SUM_FULL > SUM_CAP) ? SUM_CAP : SUM_FULL);

    // input tdata layout
    localparam int IN_DATA_W = 136;
    localparam int OFS_ENTRY = 0;
    localparam int OFS_NONE  = OFS_ENTRY + ADDR_W;
    localparam int OFS_BLUE  = OFS_NONE + COUNT_W;
    localparam int OFS_RED   = OFS_BLUE + COUNT_W;
    localparam int OFS_YEL   = OFS_RED + COUNT_W;
    localparam int OFS_CH_R  = OFS_YEL + COUNT_W;
    localparam int OFS_CH_G  = OFS_CH_R + CH_W;
    localparam int OFS_CH_B  = OFS_CH_G + CH_W;

    // output tdata layout
    localparam int OUT_DATA_W = 120;

    localparam int QMAX  = LEVELS - 1;
    localparam int IDX_W = 24;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam int CLS_NONE   = 0;
    localparam int CLS_BLUE   = 1;
    localparam int CLS_RED    = 2;
    localparam int CLS_YELLOW = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC,
        ST_FLAG
    } state_t;

    function automatic logic [CH_W-1:0] quant_ch(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] q;
        q = CH_W'(ch / QUANT_STEP);
        if (int'(q) > QMAX)
        begin
            q = CH_W'(QMAX);
        end
        return q;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(input logic [CH_W-1:0] r,
                                                     input logic [CH_W-1:0] g,
                                                     input logic [CH_W-1:0] b);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(quant_ch(r))
            + IDX_W'(LEVELS) * IDX_W'(quant_ch(g))
            + IDX_W'(LEVELS * LEVELS) * IDX_W'(quant_ch(b));
        return idx[ADDR_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [FRAC_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W + 1)'(v);
        return (s > (SUM_W + 1)'(SUM_LIMIT)) ? SUM_LIMIT : s[SUM_W-1:0];
    endfunction

endpackage

@@ sv/tclc_ram.sv @@
// tclc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tclc_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tile_color_lut_classifier_top.sv @@
// tile_color_lut_classifier_top: color lookup-table tile classifier
// depends on tclc_pkg and tclc_ram
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid / tready         tdata, tuser = func, tlast = last_pixel
//   m_axis    out  tvalid / tready         tdata (sums and class flags)
//   cfg       in   cfg_wr_en, no wait      cfg_wr_data = alpha_q8
//
// a pixel goes through table read, then accumulate, and on the last pixel of a tile
// also through flag compare into the output register
// a load with nonzero total runs the shared restoring divider, which makes
// one quotient bit per cycle, 17 bits for each of the four classes in turn
// a load with all counts zero writes a zero cell straight away, with no divide
// the output register frees the input side; only the last pixel waits for it
// after reset the sums are zero and alpha is 1.0; table cells are unset
module tile_color_lut_classifier_top
    import tclc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, count_none, count_blue, count_red, count_yellow, red, green,
    // blue, zero pad
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sum_none, sum_blue, sum_red, sum_yellow, tile_is_blue, tile_is_red,
    // tile_is_yellow, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [ALPHA_W-1:0]     cfg_wr_data
);

    state_t state_reg;
    state_t state_next;

    logic [ALPHA_W-1:0]    alpha_reg;
    logic [SUM_W-1:0]      acc_reg [NCLASS];
    logic [COUNT_W-1:0]    cnt_reg [NCLASS];
    logic [TOTAL_W-1:0]    total_reg;
    logic [ADDR_W-1:0]     entry_reg;
    logic [TOTAL_W:0]      rem_reg;
    logic [FRAC_W-1:0]     quo_reg;
    logic [FRAC_W-1:0]     frac_reg [NCLASS-1];
    logic [STEP_W-1:0]     step_reg;
    logic [1:0]            cls_reg;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                  in_xfer;
    logic                  load_xfer;
    logic                  pix_xfer;
    logic                  zero_load;
    logic [COUNT_W-1:0]    in_cnt [NCLASS];
    logic [TOTAL_W-1:0]    in_total;
    logic [ADDR_W-1:0]     pix_index;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  div_bit;
    logic [TOTAL_W:0]      div_rem;
    logic [FRAC_W-1:0]     div_quo;
    logic                  div_done;

    logic                  out_free;
    logic [ALPHA_W+SUM_W-1:0] none_scaled;
    logic                  beats [NCLASS];
    logic                  blue_win;
    logic                  red_win;
    logic                  yellow_win;
    logic [OUT_DATA_W-1:0] out_next;

    assign in_cnt[CLS_NONE]   = s_axis_tdata[OFS_NONE +: COUNT_W];
    assign in_cnt[CLS_BLUE]   = s_axis_tdata[OFS_BLUE +: COUNT_W];
    assign in_cnt[CLS_RED]    = s_axis_tdata[OFS_RED +: COUNT_W];
    assign in_cnt[CLS_YELLOW] = s_axis_tdata[OFS_YEL +: COUNT_W];

    assign in_total = TOTAL_W'(in_cnt[0]) + TOTAL_W'(in_cnt[1])
                    + TOTAL_W'(in_cnt[2]) + TOTAL_W'(in_cnt[3]);
    assign zero_load = ~|{in_cnt[0], in_cnt[1], in_cnt[2], in_cnt[3]};

    assign pix_index = cell_index(s_axis_tdata[OFS_CH_R +: CH_W],
                                  s_axis_tdata[OFS_CH_G +: CH_W],
                                  s_axis_tdata[OFS_CH_B +: CH_W]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer   = s_axis_tvalid & s_axis_tready;
    assign load_xfer = in_xfer & (s_axis_tuser == FUNC_LOAD);
    assign pix_xfer  = in_xfer & (s_axis_tuser == FUNC_PIXEL);

    // restoring divider step, remainder stays below twice the total
    assign div_bit  = (rem_reg >= (TOTAL_W + 1)'(total_reg));
    assign div_rem  = div_bit ? (rem_reg - (TOTAL_W + 1)'(total_reg)) : rem_reg;
    assign div_quo  = {quo_reg[FRAC_W-2:0], div_bit};
    assign div_done = (step_reg == STEP_W'(FRAC_W - 1));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = entry_reg;
        ram_wdata = {div_quo, frac_reg[2], frac_reg[1], frac_reg[0]};
        if (load_xfer && zero_load)
        begin
            ram_we    = 1'b1;
            ram_waddr = s_axis_tdata[OFS_ENTRY +: ADDR_W];
            ram_wdata = '0;
        end
        else if (state_reg == ST_DIV && div_done && cls_reg == 2'(CLS_YELLOW))
        begin
            ram_we = 1'b1;
        end
    end

    tclc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pix_xfer),
        .raddr (pix_index),
        .rdata (ram_rdata)
    );

    // class tests
    assign out_free    = ~out_valid_reg | m_axis_tready;
    assign none_scaled = (ALPHA_W + SUM_W)'(acc_reg[CLS_NONE])
                       * (ALPHA_W + SUM_W)'(alpha_reg);

    always_comb
    begin
        for (int k = 0; k < NCLASS; k++)
        begin
            beats[k] = ((ALPHA_W + SUM_W)'({acc_reg[k], 8'd0}) > none_scaled);
        end
    end

    assign blue_win = beats[CLS_BLUE]
                    && acc_reg[CLS_BLUE] >= acc_reg[CLS_RED]
                    && acc_reg[CLS_BLUE] >= acc_reg[CLS_YELLOW];
    assign red_win = beats[CLS_RED]
                   && acc_reg[CLS_RED] >= acc_reg[CLS_BLUE]
                   && acc_reg[CLS_RED] >= acc_reg[CLS_YELLOW];
    assign yellow_win = beats[CLS_YELLOW]
                      && acc_reg[CLS_YELLOW] >= acc_reg[CLS_BLUE]
                      && acc_reg[CLS_YELLOW] >= acc_reg[CLS_RED];

    assign out_next = {1'b0, yellow_win, red_win, blue_win,
                       acc_reg[CLS_YELLOW], acc_reg[CLS_RED],
                       acc_reg[CLS_BLUE], acc_reg[CLS_NONE]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_xfer && !zero_load)
                begin
                    state_next = ST_DIV;
                end
                else if (pix_xfer)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_DIV:
            begin
                if (div_done && cls_reg == 2'(CLS_YELLOW))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_FLAG : ST_IDLE;
            end
            ST_FLAG:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            cls_reg       <= '0;
            for (int k = 0; k < NCLASS; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                alpha_reg <= cfg_wr_data;
            end
            if (state_reg == ST_FLAG && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    cls_reg  <= '0;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        step_reg <= '0;
                        cls_reg  <= cls_reg + 2'd1;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_ACC:
                begin
                    for (int k = 0; k < NCLASS; k++)
                    begin
                        acc_reg[k] <= sat_add(acc_reg[k], ram_rdata[k*FRAC_W +: FRAC_W]);
                    end
                end
                ST_FLAG:
                begin
                    if (out_free)
                    begin
                        for (int k = 0; k < NCLASS; k++)
                        begin
                            acc_reg[k] <= '0;
                        end
                    end
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load_xfer)
        begin
            entry_reg <= s_axis_tdata[OFS_ENTRY +: ADDR_W];
            total_reg <= in_total;
            rem_reg   <= (TOTAL_W + 1)'(in_cnt[CLS_NONE]);
            quo_reg   <= '0;
            for (int k = 0; k < NCLASS; k++)
            begin
                cnt_reg[k] <= in_cnt[k];
            end
        end
        if (pix_xfer)
        begin
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_DIV)
        begin
            if (div_done)
            begin
                if (cls_reg != 2'(CLS_YELLOW))
                begin
                    frac_reg[cls_reg] <= div_quo;
                    rem_reg <= (TOTAL_W + 1)'(cnt_reg[cls_reg + 2'd1]);
                end
                quo_reg <= '0;
            end
            else
            begin
                rem_reg <= {div_rem[TOTAL_W-1:0], 1'b0};
                quo_reg <= div_quo;
            end
        end
        if (state_reg == ST_FLAG && out_free)
        begin
            out_data_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sim/tb_tile_color_lut_classifier_top.sv @@
`timescale 1ns / 1ps
// tb_tile_color_lut_classifier_top: self-checking bench for the lut tile classifier
// loads table cells, streams pixel tiles and checks every tile report against its own lut model
// depends on tclc_pkg and tile_color_lut_classifier_top
module tb_tile_color_lut_classifier_top;
    import tclc_pkg::*;

    localparam int CH_RED         = 0;
    localparam int CH_GREEN       = 1;
    localparam int CH_BLUE        = 2;
    localparam int FLAG_BLUE      = 0;
    localparam int FLAG_RED       = 1;
    localparam int FLAG_YELLOW    = 2;
    localparam int OUT_FLAG_OFS   = NCLASS * SUM_W;
    localparam int LOAD_SETTLE    = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    typedef logic [NCLASS-1:0][COUNT_W-1:0] class_counts_t;

    typedef struct packed {
        logic                     func;
        logic [ADDR_W-1:0]        entry;
        class_counts_t            cnt;
        logic [2:0][CH_W-1:0]     ch;
        logic                     last;
    } tile_item_t;

    typedef struct packed {
        logic [NCLASS-1:0][SUM_W-1:0] sum;
        logic [2:0]                   flag;
    } tile_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wr_en;
    logic [ALPHA_W-1:0]    cfg_wr_data;

    // lut model state
    logic [NCLASS-1:0][FRAC_W-1:0] lut_frac [TABLE_DEPTH];
    bit                            cell_loaded [TABLE_DEPTH];
    int unsigned                   loaded_cells [$];
    logic [NCLASS-1:0][SUM_W-1:0]  tile_acc;
    logic [ALPHA_W-1:0]            alpha_model;
    tile_report_t                  pending_reports [$];

    int          error_count   = 0;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          rx_hold_req   = 0;
    int          rx_hold_left  = 0;
    int          idle_cycles   = 0;
    tile_report_t want_report;

    tile_color_lut_classifier_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned color_level(input logic [CH_W-1:0] ch);
        int unsigned q;
        q = ch / QUANT_STEP;
        if (q > LEVELS - 1)
        begin
            q = LEVELS - 1;
        end
        return q;
    endfunction

    function automatic int unsigned lut_cell(input logic [2:0][CH_W-1:0] ch);
        int unsigned idx;
        idx = color_level(ch[CH_RED]) + LEVELS * color_level(ch[CH_GREEN])
            + LEVELS * LEVELS * color_level(ch[CH_BLUE]);
        return idx % TABLE_DEPTH;
    endfunction

    function automatic logic [SUM_W-1:0] capped_sum(input logic [SUM_W-1:0] acc,
                                                    input logic [FRAC_W-1:0] frac);
        longint unsigned s;
        s = longint'(acc) + longint'(frac);
        return (s > SUM_LIMIT) ? SUM_LIMIT : s[SUM_W-1:0];
    endfunction

    function automatic logic class_wins(input logic [SUM_W-1:0] cls,
                                        input logic [SUM_W-1:0] none,
                                        input logic [SUM_W-1:0] other_a,
                                        input logic [SUM_W-1:0] other_b);
        longint unsigned lhs;
        longint unsigned rhs;
        lhs = longint'(cls) * 256;
        rhs = longint'(none) * longint'(alpha_model);
        return (lhs > rhs) && (cls >= other_a) && (cls >= other_b);
    endfunction

    // advance the lut model by one accepted transfer
    task automatic classify_item(input tile_item_t it);
        longint unsigned total;
        longint unsigned frac;
        tile_report_t    rpt;
        int unsigned     slot;
        int              k;
        if (it.func == FUNC_LOAD)
        begin
            total = 0;
            for (k = 0; k < NCLASS; k++)
            begin
                total += it.cnt[k];
            end
            for (k = 0; k < NCLASS; k++)
            begin
                frac = (total == 0) ? 0 : (longint'(it.cnt[k]) * 65536) / total;
                lut_frac[it.entry][k] = frac[FRAC_W-1:0];
            end
            if (!cell_loaded[it.entry])
            begin
                cell_loaded[it.entry] = 1'b1;
                loaded_cells.insert(loaded_cells.size(), it.entry);
            end
        end
        else
        begin
            slot = lut_cell(it.ch);
            for (k = 0; k < NCLASS; k++)
            begin
                tile_acc[k] = capped_sum(tile_acc[k], lut_frac[slot][k]);
            end
            if (it.last)
            begin
                rpt.sum = tile_acc;
                rpt.flag[FLAG_BLUE] = class_wins(tile_acc[CLS_BLUE], tile_acc[CLS_NONE],
                                                 tile_acc[CLS_RED], tile_acc[CLS_YELLOW]);
                rpt.flag[FLAG_RED] = class_wins(tile_acc[CLS_RED], tile_acc[CLS_NONE],
                                                tile_acc[CLS_BLUE], tile_acc[CLS_YELLOW]);
                rpt.flag[FLAG_YELLOW] = class_wins(tile_acc[CLS_YELLOW], tile_acc[CLS_NONE],
                                                   tile_acc[CLS_BLUE], tile_acc[CLS_RED]);
                pending_reports.insert(pending_reports.size(), rpt);
                tile_acc = '0;
            end
        end
    endtask

    function automatic tile_item_t rand_fields();
        tile_item_t it;
        int         k;
        it.func  = 1'($urandom_range(1));
        it.entry = ADDR_W'($urandom);
        for (k = 0; k < NCLASS; k++)
        begin
            it.cnt[k] = COUNT_W'($urandom);
        end
        for (k = 0; k < 3; k++)
        begin
            it.ch[k] = CH_W'($urandom);
        end
        it.last = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic class_counts_t counts4(input logic [COUNT_W-1:0] n,
                                              input logic [COUNT_W-1:0] b,
                                              input logic [COUNT_W-1:0] r,
                                              input logic [COUNT_W-1:0] y);
        class_counts_t c;
        c[CLS_NONE]   = n;
        c[CLS_BLUE]   = b;
        c[CLS_RED]    = r;
        c[CLS_YELLOW] = y;
        return c;
    endfunction

    function automatic class_counts_t rand_counts();
        class_counts_t c;
        int            k;
        c = '0;
        case ($urandom_range(5))
            0: c = '0;
            1:
            begin
                c[$urandom_range(NCLASS - 1)] = COUNT_W'($urandom_range(1, COUNT_MAX));
            end
            2:
            begin
                for (k = 0; k < NCLASS; k++)
                begin
                    c[k] = COUNT_W'($urandom_range(15));
                end
            end
            default:
            begin
                for (k = 0; k < NCLASS; k++)
                begin
                    c[k] = COUNT_W'($urandom);
                end
            end
        endcase
        return c;
    endfunction

    function automatic tile_item_t load_item(input int unsigned entry,
                                             input class_counts_t counts);
        tile_item_t it;
        it       = rand_fields();
        it.func  = FUNC_LOAD;
        it.entry = ADDR_W'(entry);
        it.cnt   = counts;
        return it;
    endfunction

    function automatic tile_item_t pixel_item(input int unsigned slot, input logic last);
        tile_item_t it;
        it               = rand_fields();
        it.func          = FUNC_PIXEL;
        it.last          = last;
        it.ch[CH_RED]    = CH_W'((slot % LEVELS) * QUANT_STEP
                                 + $urandom_range(QUANT_STEP - 1));
        it.ch[CH_GREEN]  = CH_W'(((slot / LEVELS) % LEVELS) * QUANT_STEP
                                 + $urandom_range(QUANT_STEP - 1));
        it.ch[CH_BLUE]   = CH_W'(((slot / (LEVELS * LEVELS)) % LEVELS) * QUANT_STEP
                                 + $urandom_range(QUANT_STEP - 1));
        return it;
    endfunction

    function automatic int unsigned pick_cell();
        return loaded_cells[$urandom_range(loaded_cells.size() - 1)];
    endfunction

    task automatic send_item(input tile_item_t it);
        logic [IN_DATA_W-1:0] data;
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        data = '0;
        data[OFS_ENTRY +: ADDR_W] = it.entry;
        data[OFS_NONE  +: COUNT_W] = it.cnt[CLS_NONE];
        data[OFS_BLUE  +: COUNT_W] = it.cnt[CLS_BLUE];
        data[OFS_RED   +: COUNT_W] = it.cnt[CLS_RED];
        data[OFS_YEL   +: COUNT_W] = it.cnt[CLS_YELLOW];
        data[OFS_CH_R  +: CH_W] = it.ch[CH_RED];
        data[OFS_CH_G  +: CH_W] = it.ch[CH_GREEN];
        data[OFS_CH_B  +: CH_W] = it.ch[CH_BLUE];
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= it.func;
        s_axis_tlast  <= it.last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        classify_item(it);
    endtask

    // stop offering, let every report drain and any table load finish
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LOAD_SETTLE) @(posedge clk);
    endtask

    task automatic set_alpha(input logic [ALPHA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        alpha_model = value;
    endtask

    task automatic test_table_loads();
        send_item(load_item(0, counts4(0, 0, 0, 0)));
        send_item(load_item(TABLE_DEPTH - 1, counts4(COUNT_MAX, COUNT_MAX, COUNT_MAX,
                                                     COUNT_MAX)));
        send_item(load_item(1, counts4(COUNT_MAX, 0, 0, 0)));
        send_item(load_item(2, counts4(0, 1, 0, 0)));
        send_item(load_item(3, counts4(0, 0, 7, 0)));
        send_item(load_item(4, counts4(0, 0, 0, 3)));
        send_item(load_item(12'h555, counts4(1, 2, 3, COUNT_MAX)));
        send_item(load_item(12'hAAA, rand_counts()));
        wait_idle();
    endtask

    task automatic test_pixel_tiles();
        tile_item_t it;
        // darkest and brightest pixels hit the corner cells
        it = pixel_item(0, 1'b1);
        it.ch = '0;
        send_item(it);
        it = pixel_item(TABLE_DEPTH - 1, 1'b0);
        it.ch = '1;
        send_item(it);
        send_item(pixel_item(TABLE_DEPTH - 1, 1'b1));
        send_item(pixel_item(2, 1'b1));
        // red and yellow tie
        send_item(pixel_item(3, 1'b0));
        send_item(pixel_item(4, 1'b1));
        send_item(pixel_item(1, 1'b0));
        send_item(pixel_item(12'h555, 1'b0));
        send_item(pixel_item(12'hAAA, 1'b1));
        wait_idle();
    endtask

    task automatic test_alpha_weights();
        set_alpha('0);
        send_item(pixel_item(TABLE_DEPTH - 1, 1'b1));
        wait_idle();
        set_alpha(ALPHA_MAX);
        send_item(pixel_item(2, 1'b0));
        send_item(pixel_item(1, 1'b1));
        send_item(pixel_item(2, 1'b1));
        wait_idle();
        set_alpha(16'd128);
        send_item(pixel_item(TABLE_DEPTH - 1, 1'b1));
        wait_idle();
    endtask

    task automatic test_random(input int n_items, input int src_pct, input int snk_pct,
                               input logic [ALPHA_W-1:0] alpha);
        int sent;
        int tile_len;
        int k;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        set_alpha(alpha);
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_item(load_item($urandom_range(TABLE_DEPTH - 1), rand_counts()));
                sent++;
            end
            else
            begin
                tile_len = ($urandom_range(9) == 0) ? $urandom_range(7, 40)
                                                     : $urandom_range(1, 6);
                for (k = 1; k <= tile_len; k++)
                begin
                    send_item(pixel_item(pick_cell(), k == tile_len));
                end
                sent += tile_len;
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int k;
        src_idle_pct = 0;
        rx_hold_req  = HOLD_CYCLES;
        for (k = 0; k < 40; k++)
        begin
            send_item(pixel_item(pick_cell(), 1'b1));
        end
        wait_idle();
    endtask

    // receiver side: random stalls plus one long hold on request
    always @(negedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("tile report with none pending: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want_report = pending_reports.pop_front();
                check_field("sum_none", want_report.sum[CLS_NONE],
                            m_axis_tdata[CLS_NONE * SUM_W +: SUM_W]);
                check_field("sum_blue", want_report.sum[CLS_BLUE],
                            m_axis_tdata[CLS_BLUE * SUM_W +: SUM_W]);
                check_field("sum_red", want_report.sum[CLS_RED],
                            m_axis_tdata[CLS_RED * SUM_W +: SUM_W]);
                check_field("sum_yellow", want_report.sum[CLS_YELLOW],
                            m_axis_tdata[CLS_YELLOW * SUM_W +: SUM_W]);
                check_field("tile_is_blue", want_report.flag[FLAG_BLUE],
                            m_axis_tdata[OUT_FLAG_OFS + FLAG_BLUE]);
                check_field("tile_is_red", want_report.flag[FLAG_RED],
                            m_axis_tdata[OUT_FLAG_OFS + FLAG_RED]);
                check_field("tile_is_yellow", want_report.flag[FLAG_YELLOW],
                            m_axis_tdata[OUT_FLAG_OFS + FLAG_YELLOW]);
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[tile_color_lut_classifier_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOAD;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        tile_acc      = '0;
        alpha_model   = ALPHA_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_table_loads();
        test_pixel_tiles();
        test_alpha_weights();
        test_random(200, 20, 49, 16'($urandom_range(64, 512)));
        test_random(200, 49, 20, ALPHA_RESET);
        test_random(200, 0, 0, 16'($urandom_range(64, 512)));
        test_backpressure();
        wait_idle();

        if (error_count == 0)
        begin
            $display("[tile_color_lut_classifier_top] OK");
        end
        else
        begin
            $display("[tile_color_lut_classifier_top] ERROR");
        end
        $finish;
    end

endmodule
